>>> rtl/x86as_pkg.sv
`default_nettype none

package x86as_pkg;

    localparam int unsigned DataW = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_INC = 2'd2,
        CMD_SBB = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } t_width;

    localparam logic [DataW-1:0] NibbleCarryBit = 64'h08;

    // Decoded operation leaving stage 1.
    typedef struct packed {
        t_cmd             cmd;
        t_width           width;
        logic             cin;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] addend;
        logic             cadd;
    } t_s1;

    // Raw sum leaving stage 2.
    typedef struct packed {
        t_cmd             cmd;
        t_width           width;
        logic             cin;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] res;
    } t_s2;

    // Final item.
    typedef struct packed {
        logic [DataW-1:0] res;
        logic             cf;
        logic             af;
        logic             of;
        logic             sf;
        logic             zf;
        logic             pf;
    } t_res;

    function automatic logic [DataW-1:0] width_mask(input t_width w);
        logic [DataW-1:0] m;
        case (w)
            W8:      m = 64'h0000_0000_0000_00ff;
            W16:     m = 64'h0000_0000_0000_ffff;
            W32:     m = 64'h0000_0000_ffff_ffff;
            W64:     m = 64'hffff_ffff_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    // Top bit of a value at the operand width.
    function automatic logic top_bit(input logic [DataW-1:0] v, input t_width w);
        logic t;
        case (w)
            W8:      t = v[7];
            W16:     t = v[15];
            W32:     t = v[31];
            W64:     t = v[63];
            default: t = v[63];
        endcase
        return t;
    endfunction

    // Bit just below the top.
    function automatic logic next_bit(input logic [DataW-1:0] v, input t_width w);
        logic t;
        case (w)
            W8:      t = v[6];
            W16:     t = v[14];
            W32:     t = v[30];
            W64:     t = v[62];
            default: t = v[62];
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/x86as_decode.sv
`default_nettype none

module x86as_decode
    import x86as_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_cmd             i_cmd,
    input  wire t_width           i_width,
    input  wire logic [DataW-1:0] i_a,
    input  wire logic [DataW-1:0] i_b,
    input  wire logic             i_cin,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_s1                   o_data,
    input  wire logic             i_ready
);

    logic             r_valid;
    t_s1              r_data;
    t_s1              n_data;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] b_eff;
    logic             is_sub;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        mask   = width_mask(i_width);
        is_sub = (i_cmd == CMD_SUB) || (i_cmd == CMD_SBB);
        b_eff  = (i_cmd == CMD_INC) ? DataW'(1) : (i_b & mask);

        n_data.cmd    = i_cmd;
        n_data.width  = i_width;
        n_data.cin    = i_cin;
        n_data.a      = i_a & mask;
        n_data.b      = b_eff;
        // a - b - borrow == a + ~b + !borrow
        n_data.addend = is_sub ? (~b_eff & mask) : b_eff;
        n_data.cadd   = is_sub ? !((i_cmd == CMD_SBB) && i_cin) : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/x86as_adder.sv
`default_nettype none

module x86as_adder
    import x86as_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_s1  i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_s2       o_data,
    input  wire logic i_ready
);

    logic             r_valid;
    t_s2              r_data;
    t_s2              n_data;
    logic [DataW-1:0] sum;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        sum = i_data.a + i_data.addend + DataW'(i_data.cadd);

        n_data.cmd   = i_data.cmd;
        n_data.width = i_data.width;
        n_data.cin   = i_data.cin;
        n_data.a     = i_data.a;
        n_data.b     = i_data.b;
        n_data.res   = sum & width_mask(i_data.width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/x86as_flags.sv
`default_nettype none

module x86as_flags
    import x86as_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_s2  i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_res      o_data,
    input  wire logic i_ready
);

    logic             r_valid;
    t_res             r_data;
    t_res             n_data;
    t_cmd             r_cmd;
    t_width           r_width;
    logic             r_cin;
    logic [DataW-1:0] chain;
    logic             is_sub;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        is_sub = (i_data.cmd == CMD_SUB) || (i_data.cmd == CMD_SBB);
        // carry / borrow out of every bit position
        if (is_sub) begin
            chain = (~i_data.a & i_data.b) | ((~i_data.a | i_data.b) & i_data.res);
        end else begin
            chain = (~i_data.res & (i_data.a | i_data.b)) | (i_data.a & i_data.b);
        end

        n_data.res = i_data.res;
        n_data.cf  = (i_data.cmd == CMD_INC) ? i_data.cin : top_bit(chain, i_data.width);
        n_data.af  = |(chain & NibbleCarryBit);
        n_data.of  = top_bit(chain, i_data.width) ^ next_bit(chain, i_data.width);
        n_data.sf  = top_bit(i_data.res, i_data.width);
        n_data.zf  = (i_data.res == '0);
        n_data.pf  = ~^i_data.res[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data  <= n_data;
            r_cmd   <= i_data.cmd;
            r_width <= i_data.width;
            r_cin   <= i_data.cin;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_w8_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_width == W8) |-> (r_data.res[DataW-1:8] == '0))
        else $error("8-bit result has upper bits set");

    a_w16_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_width == W16) |-> (r_data.res[DataW-1:16] == '0))
        else $error("16-bit result has upper bits set");

    a_inc_keeps_cf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_cmd == CMD_INC) |-> (r_data.cf == r_cin))
        else $error("inc changed the carry flag");

    a_zero_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_data.zf |-> (!r_data.sf && r_data.pf))
        else $error("zero result with sign set or odd parity");

endmodule

`default_nettype wire

>>> rtl/x86_add_sub_flags_alu.sv
// An accepted item passes through the decode, add and flags registers in turn.
// Throughput: one item per cycle while the output is not stalled.
// Ready ripples back through the three stages, so a bubble is filled at once,
// but a stalled result backs up the pipe and the input stalls once all three
// stages hold an item. The 64-bit adder in stage 2 sets the clock-path depth.
// Reset: synchronous, active low; clears all stage valid bits only.
`default_nettype none

module x86_add_sub_flags_alu
    import x86as_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input item stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [63:0] operand_a, [127:64] operand_b, [128] carry_in, [135:129] zero
    input  wire logic [135:0] i_s_axis_tdata,
    // [1:0] command, [3:2] width_code
    input  wire logic [3:0]   i_s_axis_tuser,
    // result item stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [63:0] result, [64] carry_flag, [65] adjust_flag, [66] overflow_flag,
    // [67] sign_flag, [68] zero_flag, [69] parity_flag, [71:70] zero
    output logic [71:0]       o_m_axis_tdata
);

    // stage 1 -> stage 2
    logic v1;
    logic rdy2;
    t_s1  d1;
    // stage 2 -> stage 3
    logic v2;
    logic rdy3;
    t_s2  d2;
    // stage 3 output register
    t_res d3;

    // Stage 1: mask operands to width, form adder addend and carry-in.
    x86as_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_cmd   (t_cmd'(i_s_axis_tuser[1:0])),
        .i_width (t_width'(i_s_axis_tuser[3:2])),
        .i_a     (i_s_axis_tdata[63:0]),
        .i_b     (i_s_axis_tdata[127:64]),
        .i_cin   (i_s_axis_tdata[128]),
        .o_ready (o_s_axis_tready),
        .o_valid (v1),
        .o_data  (d1),
        .i_ready (rdy2)
    );

    // Stage 2: one 64-bit add; sub/sbb run as a + ~b + !borrow.
    x86as_adder u_adder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_data  (d1),
        .o_ready (rdy2),
        .o_valid (v2),
        .o_data  (d2),
        .i_ready (rdy3)
    );

    // Stage 3: carry chain rebuild and flag extraction; doubles as output reg.
    x86as_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .i_data  (d2),
        .o_ready (rdy3),
        .o_valid (o_m_axis_tvalid),
        .o_data  (d3),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {2'b00, d3.pf, d3.zf, d3.sf, d3.of, d3.af, d3.cf, d3.res};

endmodule

`default_nettype wire
